/* rtl/core/rhh_pkg.sv */
`timescale 1ns / 1ps
package rhh_pkg;

  localparam int CH_W  = 8;
  localparam int NUM_W = 18;
  localparam int DEN_W = 9;
  localparam int Q_W   = 9;

  localparam logic [2:0] ADDR_MODE = 3'd0;

  typedef enum logic {
    MODE_HSV = 1'b0,
    MODE_HSL = 1'b1
  } mode_t;

  typedef struct packed {
    logic       grey;
    logic       neg;
    logic [8:0] level;
  } side_t;

endpackage

/* rtl/core/rhh_div.sv */
`timescale 1ns / 1ps
module rhh_div import rhh_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  logic [NUM_W-1:0] rem [Q_W];
  logic [DEN_W-1:0] dv  [Q_W];
  logic [Q_W-1:0]   q   [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_step
    localparam int K = Q_W - 1 - i;
    logic [NUM_W-1:0]     r_in;
    logic [DEN_W-1:0]     d_in;
    logic [Q_W-1:0]       q_in;
    logic [NUM_W+Q_W-1:0] sh;
    logic                 ge;
    logic [Q_W-1:0]       qn;
    if (i == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem[i-1];
      assign d_in = dv[i-1];
      assign q_in = q[i-1];
    end
    assign sh = {{(NUM_W+Q_W-DEN_W){1'b0}}, d_in} << K;
    assign ge = {{Q_W{1'b0}}, r_in} >= sh;
    always_comb begin
      qn    = q_in;
      qn[K] = ge;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? r_in - sh[NUM_W-1:0] : r_in;
        dv[i]  <= d_in;
        q[i]   <= qn;
      end
    end
  end

  assign quo = q[Q_W-1];

endmodule

/* rtl/core/rgb_to_hsv_hsl.sv */
`timescale 1ns / 1ps
// Channel  | Signals                          | Direction
// pixel in | valid, ready, red, green, blue   | into the block
// result   | out_valid, out_ready, hue,       | out of the block
//          | saturation, level                |
// config   | psel, penable, pwrite, paddr,    | APB register port
//          | pwdata, prdata, pready           |
// One beat enters per clock unless a held result beat stalls the pipeline.
// The depth is an input register plus two nine-stage restoring dividers side by side.
// Reset clears the mode register to HSV and empties the pipeline.
// When the result beat is held, the whole pipeline stalls in place.
module rgb_to_hsv_hsl import rhh_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid,
  output logic             ready,
  input  logic [CH_W-1:0]  red,
  input  logic [CH_W-1:0]  green,
  input  logic [CH_W-1:0]  blue,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [8:0]       hue,
  output logic [7:0]       saturation,
  output logic [8:0]       level,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  mode_t mode;
  logic  en;
  logic  vld [Q_W+1];
  side_t side [Q_W+1];

  logic [CH_W-1:0]  mx, mn, d;
  logic [10:0]      m;
  logic [8:0]       sum, sden;
  logic [NUM_W-1:0] hnum, snum, hnum_r, snum_r;
  logic [DEN_W-1:0] hden, sden2, hden_r, sden_r;
  logic [Q_W-1:0]   hq, sq;
  side_t            side_next;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MODE) ? {31'd0, mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_HSV;
    end else if (psel && penable && pwrite && paddr == ADDR_MODE) begin
      mode <= mode_t'(pwdata[0]);
    end
  end

  assign en    = !vld[Q_W] || out_ready;
  assign ready = en;

  always_comb begin
    if (red > green) begin
      mx = red;
      mn = green;
    end else begin
      mx = green;
      mn = red;
    end
    if (blue > mx) begin
      mx = blue;
    end else if (blue < mn) begin
      mn = blue;
    end
    d   = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    priority if (mx == red) begin
      m = (green >= blue) ? {3'd0, green - blue} : {3'd0, blue - green};
    end else if (mx == green) begin
      m = {2'd0, d, 1'b0} + {3'd0, blue} - {3'd0, red};
    end else begin
      m = {1'b0, d, 2'b0} + {3'd0, red} - {3'd0, green};
    end
    hnum = {7'd0, m} * 18'd120 + {10'd0, d};
    if (mode == MODE_HSV) begin
      sden = {1'b0, mx};
    end else begin
      sden = (sum >= 9'd255) ? 9'd510 - sum : sum;
    end
    snum  = {10'd0, d} * 18'd510 + {9'd0, sden};
    hden  = (d == '0) ? 9'd2 : {d, 1'b0};
    sden2 = (d == '0) ? 9'd2 : {sden[7:0], 1'b0};
    side_next.grey  = (d == '0);
    side_next.neg   = (mx == red) && (green < blue);
    side_next.level = (mode == MODE_HSV) ? {1'b0, mx} : sum;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hnum_r  <= hnum;
      snum_r  <= snum;
      hden_r  <= hden;
      sden_r  <= sden2;
      side[0] <= side_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= valid;
    end
  end

  for (genvar i = 0; i < Q_W; i++) begin : g_pipe
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        side[i+1] <= side[i];
      end
    end
  end

  rhh_div u_hue_div (
    .clk (clk),
    .en  (en),
    .num (hnum_r),
    .den (hden_r),
    .quo (hq)
  );

  rhh_div u_sat_div (
    .clk (clk),
    .en  (en),
    .num (snum_r),
    .den (sden_r),
    .quo (sq)
  );

  assign out_valid = vld[Q_W];
  assign level     = side[Q_W].level;

  always_comb begin
    if (side[Q_W].grey) begin
      hue        = '0;
      saturation = '0;
    end else begin
      hue        = (side[Q_W].neg && hq != '0) ? 9'd360 - hq : hq;
      saturation = sq[7:0];
    end
  end

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hue < 9'd360) else $error("hue out of range");

  a_grey_sat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && side[Q_W].grey) |-> saturation == '0) else $error("grey beat saturated");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    (valid && ready) |=> vld[0]) else $error("accepted beat lost at entry");

endmodule
